FILE: rtl/nearest_point_search_defines.svh
// Assertion macros for the nearest point search RTL.
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest point search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest point search: next-cycle check failed");

`endif

FILE: rtl/nps_pkg.sv
// Shared constants, codes and types of the nearest point search block.
`default_nettype none

package nps_pkg;

    localparam int COORD_BITS       = 16;
    localparam int MAX_DIMS         = 4;
    localparam int ID_BITS          = 16;
    localparam int STATUS_BITS      = 2;
    localparam int DIM_BITS         = 3;
    localparam int SQ_BITS          = 2 * COORD_BITS;
    localparam int DIST_BITS        = SQ_BITS + 2;
    localparam int CAPACITY_DEFAULT = 256;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [DIM_BITS-1:0] DIM_RESET = 3'd4;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd3;

    typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] coords_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        coords_t            coords;
    } entry_t;

    typedef struct packed {
        logic               is_query;
        entry_t             entry;
        logic [MAX_DIMS-1:0] dim_mask;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/nearest_point_search.sv
// Top level of the nearest point search block.
//
// The block keeps up to CAPACITY points and answers nearest-neighbour queries under the
// squared Euclidean metric over the first 'dimension' coordinates (0 counts as 1, more
// than MAX_DIMS as MAX_DIMS). Requests enter a two-deep queue, so the input side keeps
// accepting while a result waits at the output. An add request, or a query on an empty
// store, is answered straight from the idle state. A query scans the point memory, which
// has a single read port, one entry per cycle, followed by the distance pipeline. No
// clearing pass is needed after reset; only entries already written are ever read.
`default_nettype none

module nearest_point_search
    import nps_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [DIM_BITS-1:0]    cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [ID_BITS-1:0]     point_id,
    input  logic [COORD_BITS-1:0]  coord_0,
    input  logic [COORD_BITS-1:0]  coord_1,
    input  logic [COORD_BITS-1:0]  coord_2,
    input  logic [COORD_BITS-1:0]  coord_3,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_BITS-1:0] status,
    output logic [ID_BITS-1:0]     found_id,
    output logic [COORD_BITS-1:0]  found_coord_0,
    output logic [COORD_BITS-1:0]  found_coord_1,
    output logic [COORD_BITS-1:0]  found_coord_2,
    output logic [COORD_BITS-1:0]  found_coord_3,
    output logic [DIST_BITS-1:0]   distance_squared
);

    logic [DIM_BITS-1:0] dimension_reg;
    logic                push;
    cmd_t                push_cmd;
    logic                queue_full;
    logic                pop;
    logic                not_empty;
    cmd_t                pop_cmd;
    coords_t             found_coords;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            dimension_reg <= cfg_wdata;
        end
    end

    nps_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .point_id   (point_id),
        .coord_0    (coord_0),
        .coord_1    (coord_1),
        .coord_2    (coord_2),
        .coord_3    (coord_3),
        .dimension  (dimension_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    nps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_cmd   (pop_cmd)
    );

    nps_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (not_empty),
        .cmd              (pop_cmd),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .found_id         (found_id),
        .found_coords     (found_coords),
        .distance_squared (distance_squared)
    );

    assign found_coord_0 = found_coords[0];
    assign found_coord_1 = found_coords[1];
    assign found_coord_2 = found_coords[2];
    assign found_coord_3 = found_coords[3];

endmodule

`default_nettype wire

FILE: rtl/nps_front.sv
// Front end: decodes each request and the coordinate mask it will use.
`default_nettype none

module nps_front
    import nps_pkg::*;
(
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [ID_BITS-1:0]     point_id,
    input  logic [COORD_BITS-1:0]  coord_0,
    input  logic [COORD_BITS-1:0]  coord_1,
    input  logic [COORD_BITS-1:0]  coord_2,
    input  logic [COORD_BITS-1:0]  coord_3,
    input  logic [DIM_BITS-1:0]    dimension,
    input  logic                   queue_full,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic [DIM_BITS-1:0] eff_dims;

    always_comb
    begin
        if (dimension == '0)
        begin
            eff_dims = DIM_BITS'(1);
        end
        else if (dimension > DIM_BITS'(MAX_DIMS))
        begin
            eff_dims = DIM_BITS'(MAX_DIMS);
        end
        else
        begin
            eff_dims = dimension;
        end
    end

    always_comb
    begin
        push_cmd.is_query        = (opcode == OP_QUERY);
        push_cmd.entry.id        = point_id;
        push_cmd.entry.coords[0] = coord_0;
        push_cmd.entry.coords[1] = coord_1;
        push_cmd.entry.coords[2] = coord_2;
        push_cmd.entry.coords[3] = coord_3;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            push_cmd.dim_mask[k] = (DIM_BITS'(k) < eff_dims);
        end
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

endmodule

`default_nettype wire

FILE: rtl/nps_queue.sv
// Short request queue between the front end and the search engine.
`default_nettype none

module nps_queue
    import nps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slots_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_cmd   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nps_back.sv
// Search engine: point store, pipelined distance scan and result register.
`default_nettype none

`include "nearest_point_search_defines.svh"

module nps_back
    import nps_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  cmd_t                   cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_BITS-1:0] status,
    output logic [ID_BITS-1:0]     found_id,
    output coords_t                found_coords,
    output logic [DIST_BITS-1:0]   distance_squared
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;

    logic                   out_free;
    logic                   wr_en;
    logic                   rd_en;
    logic                   scan_start;
    logic                   load;
    logic                   load_found;
    logic [STATUS_BITS-1:0] load_status;

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    logic [3:0] pv_reg;

    coords_t             q_coords_reg;
    logic [MAX_DIMS-1:0] q_mask_reg;

    logic [COORD_BITS-1:0] mag      [MAX_DIMS];
    logic [COORD_BITS-1:0] diff_reg [MAX_DIMS];
    logic [SQ_BITS-1:0]    sq_reg   [MAX_DIMS];
    logic [DIST_BITS-1:0]  sum;
    logic [DIST_BITS-1:0]  sum_reg;
    entry_t                s2_entry_reg, s3_entry_reg, s4_entry_reg;

    logic                 best_valid_reg;
    logic [DIST_BITS-1:0] best_dist_reg;
    entry_t               best_entry_reg;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [ID_BITS-1:0]     id_reg;
    coords_t                coords_reg;
    logic [DIST_BITS-1:0]   dist_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        scan_start    = 1'b0;
        load          = 1'b0;
        load_found    = 1'b0;
        load_status   = ST_ADDED;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    pop = 1'b1;
                    if (!cmd.is_query)
                    begin
                        load = 1'b1;
                        if (count_reg == CW'(CAPACITY))
                        begin
                            load_status = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CW'(1);
                            load_status = ST_ADDED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        load        = 1'b1;
                        load_status = ST_EMPTY;
                    end
                    else
                    begin
                        scan_start    = 1'b1;
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en         = 1'b1;
                scan_idx_next = scan_idx_reg + CW'(1);
                if (scan_idx_reg + CW'(1) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (pv_reg == '0)
                begin
                    load        = 1'b1;
                    load_found  = 1'b1;
                    load_status = ST_FOUND;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            pv_reg         <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            pv_reg       <= {pv_reg[2:0], rd_en};
            if (scan_start)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (pv_reg[3])
            begin
                best_valid_reg <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= cmd.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        logic signed [COORD_BITS:0] d;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            d = $signed({q_coords_reg[k][COORD_BITS-1], q_coords_reg[k]})
                - $signed({rd_data_reg.coords[k][COORD_BITS-1], rd_data_reg.coords[k]});
            if (d < 0)
            begin
                d = -d;
            end
            mag[k] = d[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            sum = sum + DIST_BITS'(sq_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            q_coords_reg <= cmd.entry.coords;
            q_mask_reg   <= cmd.dim_mask;
        end
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            diff_reg[k] <= mag[k];
            sq_reg[k]   <= q_mask_reg[k] ? diff_reg[k] * diff_reg[k] : '0;
        end
        s2_entry_reg <= rd_data_reg;
        s3_entry_reg <= s2_entry_reg;
        sum_reg      <= sum;
        s4_entry_reg <= s3_entry_reg;
        if (pv_reg[3] && (!best_valid_reg || sum_reg < best_dist_reg))
        begin
            best_dist_reg  <= sum_reg;
            best_entry_reg <= s4_entry_reg;
        end
        if (load)
        begin
            status_reg <= load_status;
            if (load_found)
            begin
                id_reg   <= best_entry_reg.id;
                dist_reg <= best_dist_reg;
                for (int k = 0; k < MAX_DIMS; k++)
                begin
                    coords_reg[k] <= q_mask_reg[k] ? best_entry_reg.coords[k] : '0;
                end
            end
            else
            begin
                id_reg     <= '0;
                dist_reg   <= '0;
                coords_reg <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign found_id         = id_reg;
    assign found_coords     = coords_reg;
    assign distance_squared = dist_reg;

    `NPS_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_reg == S_SCAN, scan_idx_reg < count_reg)
    `NPS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `NPS_ASSERT_IMPL(a_drain_out_free, clk, rst_n, state_reg == S_DRAIN, !out_valid_reg)
    `NPS_ASSERT_NEXT(a_found_loaded, clk, rst_n, (state_reg == S_DRAIN) && (pv_reg == '0), out_valid_reg && (status_reg == ST_FOUND) && best_valid_reg)

endmodule

`default_nettype wire

FILE: tb/sv/nearest_point_search_test.sv
// Self-checking testbench for the nearest point search block.
`default_nettype none

module nearest_point_search_test
    import nps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 27;

    localparam logic [COORD_BITS-1:0] C_MAX = 16'h7FFF;
    localparam logic [COORD_BITS-1:0] C_MIN = 16'h8000;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ID_BITS-1:0]     id;
        coords_t                coords;
        logic [DIST_BITS-1:0]   dist_sq;
    } result_t;

    typedef enum logic {ROW_REQUEST, ROW_DIMENSION} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [DIM_BITS-1:0] dim;
        logic                op;
        logic [ID_BITS-1:0]  id;
        coords_t             crd;
        logic                known;
        result_t             want;
    } row_t;

    localparam result_t ADDED_ANSWER = '{status: ST_ADDED, default: '0};
    localparam result_t EMPTY_ANSWER = '{status: ST_EMPTY, default: '0};
    localparam result_t NO_ANSWER    = '0;

    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'hA5A5, {4{16'h0000}}, 1'b1, EMPTY_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_ADD, 16'hFFFF, {4{C_MIN}}, 1'b1, ADDED_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {4{C_MAX}}, 1'b1,
          '{ST_FOUND, 16'hFFFF, {4{C_MIN}}, 34'd17179344900}},
        '{ROW_REQUEST, 3'd0, OP_ADD, 16'h0000, {4{C_MAX}}, 1'b1, ADDED_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'hFFFF, {4{16'h0000}}, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_ADD, 16'h0001, {4{C_MAX}}, 1'b1, ADDED_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {4{C_MAX}}, 1'b1,
          '{ST_FOUND, 16'h0000, {4{C_MAX}}, 34'd0}},
        '{ROW_REQUEST, 3'd0, OP_ADD, 16'h5A5A, {16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001},
          1'b1, ADDED_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {4{16'h0000}}, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {16'hAAAB, 16'h5554, 16'h0000, 16'h0002},
          1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd1, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {16'h1111, 16'h2222, 16'h3333, 16'h0002},
          1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {4{C_MAX}}, 1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd0, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {16'h1234, 16'h1234, 16'h1234, 16'h0001},
          1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd7, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0F0F, {4{C_MIN}}, 1'b1,
          '{ST_FOUND, 16'hFFFF, {4{C_MIN}}, 34'd0}},
        '{ROW_REQUEST, 3'd0, OP_ADD, 16'h8001, {C_MIN, C_MAX, C_MIN, C_MAX}, 1'b1,
          ADDED_ANSWER},
        '{ROW_DIMENSION, 3'd2, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {C_MAX, C_MIN, 16'h0100, 16'hFF00},
          1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd3, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {C_MIN, C_MAX, C_MIN, 16'h0000},
          1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd5, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF},
          1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd6, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, 3'd0, OP_QUERY, 16'h0000, {C_MAX, C_MIN, C_MAX, C_MIN},
          1'b0, NO_ANSWER},
        '{ROW_DIMENSION, 3'd4, OP_ADD, 16'h0000, '0, 1'b0, NO_ANSWER}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [DIM_BITS-1:0]    cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   opcode = OP_ADD;
    logic [ID_BITS-1:0]     point_id = '0;
    logic [COORD_BITS-1:0]  coord_0 = '0;
    logic [COORD_BITS-1:0]  coord_1 = '0;
    logic [COORD_BITS-1:0]  coord_2 = '0;
    logic [COORD_BITS-1:0]  coord_3 = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     found_id;
    logic [COORD_BITS-1:0]  found_coord_0;
    logic [COORD_BITS-1:0]  found_coord_1;
    logic [COORD_BITS-1:0]  found_coord_2;
    logic [COORD_BITS-1:0]  found_coord_3;
    logic [DIST_BITS-1:0]   distance_squared;

    logic [ID_BITS-1:0]  stored_ids [CAPACITY_DEFAULT];
    coords_t             stored_coords [CAPACITY_DEFAULT];
    int unsigned         stored_count = 0;
    logic [DIM_BITS-1:0] dim_setting = DIM_RESET;

    result_t     pending_answers [$];
    bit          quiet = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned stalled_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned answers_checked = 0;
    int unsigned adds_sent = 0;
    int unsigned refused_adds = 0;
    int unsigned queries_sent = 0;
    int unsigned empty_queries = 0;
    int unsigned dimension_writes = 0;

    nearest_point_search dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t lookup_nearest(input logic op, input logic [ID_BITS-1:0] id,
                                               input coords_t crd);
        result_t          ans;
        int unsigned      dims;
        int unsigned      best;
        longint unsigned  best_dist;
        longint unsigned  cand_dist;
        longint           delta;
        ans = '0;
        dims = (dim_setting == 0) ? 1 : (dim_setting > MAX_DIMS) ? MAX_DIMS : dim_setting;
        if (op == OP_ADD)
        begin
            adds_sent++;
            if (stored_count >= CAPACITY_DEFAULT)
            begin
                ans.status = ST_FULL;
                refused_adds++;
            end
            else
            begin
                stored_ids[stored_count] = id;
                stored_coords[stored_count] = crd;
                stored_count++;
                ans.status = ST_ADDED;
            end
        end
        else if (stored_count == 0)
        begin
            queries_sent++;
            empty_queries++;
            ans.status = ST_EMPTY;
        end
        else
        begin
            queries_sent++;
            best = 0;
            best_dist = 0;
            for (int unsigned i = 0; i < stored_count; i++)
            begin
                cand_dist = 0;
                for (int unsigned k = 0; k < dims; k++)
                begin
                    delta = longint'($signed(crd[k])) - longint'($signed(stored_coords[i][k]));
                    if (delta < 0)
                        delta = -delta;
                    cand_dist += delta * delta;
                end
                if (i == 0 || cand_dist < best_dist)
                begin
                    best = i;
                    best_dist = cand_dist;
                end
            end
            ans.status = ST_FOUND;
            ans.id = stored_ids[best];
            for (int unsigned k = 0; k < dims; k++)
                ans.coords[k] = stored_coords[best][k];
            ans.dist_sq = best_dist[DIST_BITS-1:0];
        end
        return ans;
    endfunction

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COORD_BITS-1:0] wild_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return C_MIN;
        if (r == 1)
            return C_MAX;
        if (r < 5)
            return COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
        return COORD_BITS'($urandom);
    endfunction

    task automatic pick_request(output logic op, output logic [ID_BITS-1:0] id,
                                output coords_t crd);
        int unsigned style;
        int unsigned src;
        op = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_QUERY;
        id = ID_BITS'($urandom);
        style = $urandom_range(0, 3);
        for (int k = 0; k < MAX_DIMS; k++)
            crd[k] = wild_coord();
        if (style < 2 && stored_count != 0)
        begin
            src = $urandom_range(0, stored_count - 1);
            crd = stored_coords[src];
            if (style == 1)
                for (int k = 0; k < MAX_DIMS; k++)
                    crd[k] = crd[k] + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
        end
    endtask

    task automatic send_request(input logic op, input logic [ID_BITS-1:0] id,
                                input coords_t crd, input logic known, input result_t want);
        int unsigned gap;
        result_t     answer;
        gap = idle_cycles();
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        point_id <= id;
        coord_0  <= crd[0];
        coord_1  <= crd[1];
        coord_2  <= crd[2];
        coord_3  <= crd[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        answer = lookup_nearest(op, id, crd);
        pending_answers.push_back(known ? want : answer);
    endtask

    task automatic finish_pending();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_dimension(input logic [DIM_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        dim_setting = value;
        dimension_writes++;
    endtask

    always @(negedge clk)
    begin
        if (ready_hold != 0)
            ready_hold = ready_hold - 1;
        else if (quiet)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin : answer_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, found_id,
                    {found_coord_3, found_coord_2, found_coord_1, found_coord_0},
                    distance_squared};
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected answer: status %0d id %h coords %h dist %0d",
                             got.status, got.id, got.coords, got.dist_sq);
            end
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected status %0d id %h coords %h dist %0d",
                                 want.status, want.id, want.coords, want.dist_sq);
                        $display("          got      status %0d id %h coords %h dist %0d",
                                 got.status, got.id, got.coords, got.dist_sq);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && pending_answers.size() == 0))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a handshake.", stalled_cycles);
            $display("nearest_point_search test failed");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin : stimulus
        logic                op;
        logic [ID_BITS-1:0]  id;
        coords_t             crd;
        int unsigned         random_sent;
        int unsigned         phase;
        int unsigned         span;
        random_sent = 0;
        phase = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_DIMENSION)
            begin
                finish_pending();
                set_dimension(DIRECTED[r].dim);
            end
            else
                send_request(DIRECTED[r].op, DIRECTED[r].id, DIRECTED[r].crd,
                             DIRECTED[r].known, DIRECTED[r].want);
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            finish_pending();
            if (phase < 8)
                set_dimension(DIM_BITS'((phase * 5 + 1) % 8));
            else
                set_dimension(DIM_BITS'($urandom_range(0, 7)));
            quiet = ($urandom_range(0, 3) == 0);
            span = $urandom_range(60, 150);
            if (span > RANDOM_ITEMS - random_sent)
                span = RANDOM_ITEMS - random_sent;
            repeat (span)
            begin
                pick_request(op, id, crd);
                send_request(op, id, crd, 1'b0, NO_ANSWER);
                random_sent++;
            end
            phase++;
        end
        quiet = 1'b0;
        finish_pending();
        repeat (20) @(posedge clk);

        $display("Run covered %0d adds (%0d refused on a full store) and %0d queries",
                 adds_sent, refused_adds, queries_sent);
        $display("(%0d on an empty store), %0d dimension writes, %0d answers checked.",
                 empty_queries, dimension_writes, answers_checked);
        if (mismatches == 0)
            $display("nearest_point_search test passed");
        else
            $display("nearest_point_search test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: nearest_point_search.f
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_front.sv
rtl/nps_queue.sv
rtl/nps_back.sv
rtl/nearest_point_search.sv
tb/sv/nearest_point_search_test.sv
